FILE: rtl/ipv4fd_pkg.sv
// Shared types, codes and helpers of the IPv4 forwarding decision unit.
package ipv4fd_pkg;

   // Input item kinds, carried on the request channel tuser.
   localparam logic [1:0] KIND_ROUTE_WR = 2'd0;
   localparam logic [1:0] KIND_NEIGH_WR = 2'd1;
   localparam logic [1:0] KIND_LOOKUP   = 2'd2;

   // Forwarding decisions, carried on the response channel tuser.
   localparam logic [2:0] ACT_FORWARD     = 3'd0;
   localparam logic [2:0] ACT_BAD_CSUM    = 3'd1;
   localparam logic [2:0] ACT_TIME_EXCEED = 3'd2;
   localparam logic [2:0] ACT_UNREACHABLE = 3'd3;
   localparam logic [2:0] ACT_NO_NEIGHBOR = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_ROUTE_COUNT = 1'b0;
   localparam logic CSR_NEIGH_COUNT = 1'b1;

   // Entries in the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Work that the back part carries out.
   typedef enum logic [1:0] {
      OP_ROUTE_WR,
      OP_NEIGH_WR,
      OP_LOOKUP,
      OP_REPLY
   } op_type;

   // Back part sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUTE,
      BK_NEIGH,
      BK_FINISH
   } back_state_type;

   // One request as unpacked from the request channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  entry_index;
      logic [31:0] route_prefix_in;
      logic [31:0] route_mask_in;
      logic [31:0] hop_address;
      logic [3:0]  interface_in;
      logic [47:0] mac_in;
      logic [31:0] dest_address;
      logic [7:0]  ttl_in;
      logic [7:0]  protocol_in;
      logic [15:0] checksum_in;
      logic        header_ok;
   } req_type;

   // One classified work item in the queue.
   typedef struct packed {
      op_type      op;
      logic [9:0]  index;
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] hop;
      logic [3:0]  iface;
      logic [47:0] mac;
      logic [31:0] dest;
      logic [7:0]  ttl;
      logic [15:0] csum;
      logic [2:0]  action;
   } work_type;

   // One forwarding result.
   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  out_interface;
      logic [47:0] next_mac;
      logic [7:0]  ttl_out;
      logic [15:0] checksum_out;
   } rsp_type;

   // Incremental header checksum update over the {TTL, protocol} word.
   function automatic logic [15:0] csum_update(input logic [15:0] hc,
                                               input logic [15:0] m_old,
                                               input logic [15:0] m_new);
      logic [17:0] s;
      logic [16:0] f1;
      logic [16:0] f2;
      s  = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
      f1 = 17'(s[15:0]) + 17'(s[17:16]);
      f2 = 17'(f1[15:0]) + 17'(f1[16]);
      return ~f2[15:0];
   endfunction

endpackage

FILE: rtl/ipv4fd_ram.sv
// Generic single-port-write, registered-read RAM.
module ipv4fd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ipv4fd_queue.sv
// Two-entry work queue between the front and back parts.
module ipv4fd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ipv4fd_pkg::work_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output ipv4fd_pkg::work_type head_item
);
   import ipv4fd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   work_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // The back part never takes from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> count_ff != '0)
      else $error("queue popped while empty");

   // The front part never adds to a full queue.
   assert property (@(posedge clock) disable iff (reset)
                    push |-> count_ff != CW'(QUEUE_DEPTH))
      else $error("queue pushed while full");

endmodule

FILE: rtl/ipv4fd_front.sv
// Front part: accepts requests, drops ignored ones and decides early outcomes.
module ipv4fd_front #(
   parameter int ROUTE_DEPTH     = 1024,
   parameter int NEIGHBOUR_DEPTH = 16
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ipv4fd_pkg::req_type  req,
   input  logic                 queue_full,
   output logic                 push,
   output ipv4fd_pkg::work_type push_item
);
   import ipv4fd_pkg::*;

   logic       accept;
   logic       keep;
   logic [7:0] ttl_dec;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign ttl_dec   = req.ttl_in - 8'd1;

   // Writes outside a table and unknown kinds are accepted and dropped.
   always_comb begin
      priority case (req.kind)
         KIND_ROUTE_WR: keep = 32'(req.entry_index) < 32'(ROUTE_DEPTH);
         KIND_NEIGH_WR: keep = 32'(req.entry_index) < 32'(NEIGHBOUR_DEPTH);
         KIND_LOOKUP:   keep = 1'b1;
         default:       keep = 1'b0;
      endcase
   end

   assign push = accept && keep;

   // Classify the request; failed checks become a finished reply.
   always_comb begin
      push_item        = '0;
      push_item.index  = req.entry_index;
      push_item.prefix = req.route_prefix_in;
      push_item.mask   = req.route_mask_in;
      push_item.hop    = req.hop_address;
      push_item.iface  = req.interface_in;
      push_item.mac    = req.mac_in;
      push_item.dest   = req.dest_address;
      push_item.ttl    = ttl_dec;
      push_item.csum   = csum_update(req.checksum_in, {req.ttl_in, req.protocol_in},
                                     {ttl_dec, req.protocol_in});
      push_item.action = ACT_FORWARD;
      if (req.kind == KIND_ROUTE_WR) begin
         push_item.op = OP_ROUTE_WR;
      end else if (req.kind == KIND_NEIGH_WR) begin
         push_item.op = OP_NEIGH_WR;
      end else if (!req.header_ok) begin
         push_item.op     = OP_REPLY;
         push_item.action = ACT_BAD_CSUM;
      end else if (req.ttl_in <= 8'd1) begin
         push_item.op     = OP_REPLY;
         push_item.action = ACT_TIME_EXCEED;
      end else begin
         push_item.op = OP_LOOKUP;
      end
   end

endmodule

FILE: rtl/ipv4fd_back.sv
// Back part: table writes, route and neighbor scans, and the result register.
module ipv4fd_back #(
   parameter int ROUTE_DEPTH     = 1024,
   parameter int NEIGHBOUR_DEPTH = 16,
   parameter int INTERFACE_BITS  = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [10:0]          route_count,
   input  logic [4:0]           neighbour_count,
   input  logic                 q_valid,
   input  ipv4fd_pkg::work_type q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ipv4fd_pkg::rsp_type  rsp
);
   import ipv4fd_pkg::*;

   localparam int RA  = ROUTE_DEPTH > 1 ? $clog2(ROUTE_DEPTH) : 1;
   localparam int NA  = NEIGHBOUR_DEPTH > 1 ? $clog2(NEIGHBOUR_DEPTH) : 1;
   localparam int RCW = $clog2(ROUTE_DEPTH + 1);
   localparam int NCW = $clog2(NEIGHBOUR_DEPTH + 1);
   localparam int IB  = INTERFACE_BITS;
   localparam int RW  = 96 + IB;
   localparam int NW  = 80;

   back_state_type state_ff, state_in;

   // Control strobes from the sequencer.
   logic route_we, neigh_we, r_issue, n_issue, load_rsp, start_lookup;

   // Scan counters and pipeline flags.
   logic [RCW-1:0] r_idx_ff;
   logic [NCW-1:0] n_idx_ff;
   logic           r_chk_ff, n_chk_ff;
   logic [RCW-1:0] rn;
   logic [NCW-1:0] nn;
   logic           r_done, n_done;

   // Item and search registers.
   logic [31:0]    dest_ff;
   logic [7:0]     ttl_ff;
   logic [15:0]    csum_ff;
   logic [2:0]     action_ff;
   logic           found_ff, have_ff;
   logic [31:0]    best_mask_ff, best_hop_ff;
   logic [IB-1:0]  best_iface_ff;
   logic [47:0]    mac_ff;

   // Table ports.
   logic [RW-1:0]  route_wdata, route_rdata;
   logic [NW-1:0]  neigh_wdata, neigh_rdata;
   logic [IB+3:0]  iface_wext;
   logic [IB+3:0]  iface_rext;
   logic [31:0]    rd_prefix, rd_mask, rd_hop;
   logic [IB-1:0]  rd_iface;
   logic [31:0]    nb_addr;
   logic [47:0]    nb_mac;
   logic           route_hit, neigh_hit;

   // Result register.
   logic           rsp_valid_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           out_free;

   // Counts beyond a table's depth search the whole table.
   assign rn = (32'(route_count) >= 32'(ROUTE_DEPTH)) ? RCW'(ROUTE_DEPTH) : RCW'(route_count);
   assign nn = (32'(neighbour_count) >= 32'(NEIGHBOUR_DEPTH)) ?
               NCW'(NEIGHBOUR_DEPTH) : NCW'(neighbour_count);

   // Route table: {interface, next hop, mask, prefix}.
   assign iface_wext  = {{IB{1'b0}}, q_item.iface};
   assign route_wdata = {iface_wext[IB-1:0], q_item.hop, q_item.mask, q_item.prefix};

   ipv4fd_ram #(.WIDTH(RW), .DEPTH(ROUTE_DEPTH)) u_route_ram (
      .clock   (clock),
      .wr_en   (route_we),
      .wr_addr (RA'(q_item.index)),
      .wr_data (route_wdata),
      .rd_addr (r_idx_ff[RA-1:0]),
      .rd_data (route_rdata)
   );

   assign rd_prefix = route_rdata[31:0];
   assign rd_mask   = route_rdata[63:32];
   assign rd_hop    = route_rdata[95:64];
   assign rd_iface  = route_rdata[RW-1:96];

   // Neighbor table: {MAC, address}.
   assign neigh_wdata = {q_item.mac, q_item.hop};

   ipv4fd_ram #(.WIDTH(NW), .DEPTH(NEIGHBOUR_DEPTH)) u_neigh_ram (
      .clock   (clock),
      .wr_en   (neigh_we),
      .wr_addr (NA'(q_item.index)),
      .wr_data (neigh_wdata),
      .rd_addr (n_idx_ff[NA-1:0]),
      .rd_data (neigh_rdata)
   );

   assign nb_addr = neigh_rdata[31:0];
   assign nb_mac  = neigh_rdata[79:32];

   // Compare the entry read in the previous cycle.
   assign route_hit = r_chk_ff && ((dest_ff & rd_mask) == rd_prefix) &&
                      (!found_ff || rd_mask > best_mask_ff);
   assign neigh_hit = n_chk_ff && !have_ff && (nb_addr == best_hop_ff);

   assign r_done   = (r_idx_ff == rn) && !r_chk_ff;
   assign n_done   = have_ff || ((n_idx_ff == nn) && !n_chk_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_LOOKUP) begin
                  state_in = BK_ROUTE;
               end else if (q_item.op == OP_REPLY) begin
                  state_in = BK_FINISH;
               end
            end
         end
         BK_ROUTE: begin
            if (r_done) begin
               state_in = found_ff ? BK_NEIGH : BK_FINISH;
            end
         end
         BK_NEIGH: begin
            if (n_done) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      q_pop        = 1'b0;
      route_we     = 1'b0;
      neigh_we     = 1'b0;
      start_lookup = 1'b0;
      r_issue      = 1'b0;
      n_issue      = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            q_pop        = q_valid;
            route_we     = q_valid && (q_item.op == OP_ROUTE_WR);
            neigh_we     = q_valid && (q_item.op == OP_NEIGH_WR);
            start_lookup = q_valid;
         end
         BK_ROUTE:  r_issue  = (r_idx_ff != rn);
         BK_NEIGH:  n_issue  = (n_idx_ff != nn) && !have_ff && !neigh_hit;
         BK_FINISH: load_rsp = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scan control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         r_idx_ff <= '0;
         n_idx_ff <= '0;
         r_chk_ff <= 1'b0;
         n_chk_ff <= 1'b0;
         found_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else if (start_lookup) begin
         r_idx_ff <= '0;
         n_idx_ff <= '0;
         r_chk_ff <= 1'b0;
         n_chk_ff <= 1'b0;
         found_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         r_chk_ff <= r_issue;
         n_chk_ff <= n_issue;
         if (r_issue) begin
            r_idx_ff <= r_idx_ff + 1'b1;
         end
         if (n_issue) begin
            n_idx_ff <= n_idx_ff + 1'b1;
         end
         if (route_hit) begin
            found_ff <= 1'b1;
         end
         if (neigh_hit) begin
            have_ff <= 1'b1;
         end
      end
   end

   // Item and best-match payload.
   always_ff @(posedge clock) begin
      if (start_lookup) begin
         dest_ff   <= q_item.dest;
         ttl_ff    <= q_item.ttl;
         csum_ff   <= q_item.csum;
         action_ff <= q_item.action;
      end
      if (route_hit) begin
         best_mask_ff  <= rd_mask;
         best_hop_ff   <= rd_hop;
         best_iface_ff <= rd_iface;
      end
      if (neigh_hit) begin
         mac_ff <= nb_mac;
      end
   end

   // Final decision and result fields.
   assign iface_rext = {4'b0000, best_iface_ff};

   always_comb begin
      rsp_in = '0;
      if (action_ff != ACT_FORWARD) begin
         rsp_in.action = action_ff;
      end else if (!found_ff) begin
         rsp_in.action = ACT_UNREACHABLE;
      end else if (!have_ff) begin
         rsp_in.action = ACT_NO_NEIGHBOR;
      end else begin
         rsp_in.action        = ACT_FORWARD;
         rsp_in.out_interface = iface_rext[3:0];
         rsp_in.next_mac      = mac_ff;
         rsp_in.ttl_out       = ttl_ff;
         rsp_in.checksum_out  = csum_ff;
      end
   end

   // Output register parts the back part from the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // The sequencer leaves reset idle.
   assert property (@(posedge clock) $past(reset) |-> state_ff == BK_IDLE)
      else $error("back part not idle after reset");

   // The route scan never reads past the searched entries.
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == BK_ROUTE |-> r_idx_ff <= rn)
      else $error("route scan overran its count");

   // A forward decision needs both a route and a neighbor.
   assert property (@(posedge clock) disable iff (reset)
                    load_rsp && rsp_in.action == ACT_FORWARD |-> found_ff && have_ff)
      else $error("forward result without route and neighbor");

endmodule

FILE: rtl/ipv4_forwarding_decision_unit.sv
// Top level of the IPv4 forwarding decision unit: channel packing and configuration.
//
// Channel   Direction  Handshake                 Content
// req_      in         req_tvalid / req_tready   tuser kind, tdata write or header fields
// rsp_      out        rsp_tvalid / rsp_tready   tuser action, tdata forwarding fields
// csr_      in         csr_valid / csr_ready     csr_index register, csr_data value
//
// A route or neighbor write is done in the back part as it is taken from the queue. A lookup is
// taken from the queue, then scans the route table over its registered read, then scans the
// neighbor table (that scan stops at the first hit and is skipped when no route matches), and
// last loads the result register; the scan counts are capped at the table depths. Reset is
// synchronous; tables need no clearing pass.
// A two-entry queue takes requests during a lookup; a held result stalls only that last step.
module ipv4_forwarding_decision_unit #(
   parameter int ROUTE_DEPTH     = 1024,
   parameter int NEIGHBOUR_DEPTH = 16,
   parameter int INTERFACE_BITS  = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind
   input  logic [1:0]   req_tuser,
   // entry_index, route_prefix_in, route_mask_in, hop_address, interface_in, mac_in,
   // dest_address, ttl_in, protocol_in, checksum_in, header_ok, zero pad
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // action
   output logic [2:0]   rsp_tuser,
   // out_interface, next_mac, ttl_out, checksum_out, zero pad
   output logic [79:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [10:0]  csr_data
);
   import ipv4fd_pkg::*;

   req_type     req;
   rsp_type     rsp;
   work_type    push_item, head_item;
   logic        push, pop, queue_full, queue_valid;
   logic [10:0] route_count_ff;
   logic [4:0]  neighbour_count_ff;

   // Unpack the request.
   assign req.kind            = req_tuser;
   assign req.entry_index     = req_tdata[9:0];
   assign req.route_prefix_in = req_tdata[41:10];
   assign req.route_mask_in   = req_tdata[73:42];
   assign req.hop_address     = req_tdata[105:74];
   assign req.interface_in    = req_tdata[109:106];
   assign req.mac_in          = req_tdata[157:110];
   assign req.dest_address    = req_tdata[189:158];
   assign req.ttl_in          = req_tdata[197:190];
   assign req.protocol_in     = req_tdata[205:198];
   assign req.checksum_in     = req_tdata[221:206];
   assign req.header_ok       = req_tdata[222];

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff     <= '0;
         neighbour_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROUTE_COUNT: route_count_ff     <= csr_data;
            CSR_NEIGH_COUNT: neighbour_count_ff <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   ipv4fd_front #(
      .ROUTE_DEPTH     (ROUTE_DEPTH),
      .NEIGHBOUR_DEPTH (NEIGHBOUR_DEPTH)
   ) u_front (
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req        (req),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   ipv4fd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .head_item (head_item)
   );

   ipv4fd_back #(
      .ROUTE_DEPTH     (ROUTE_DEPTH),
      .NEIGHBOUR_DEPTH (NEIGHBOUR_DEPTH),
      .INTERFACE_BITS  (INTERFACE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .route_count     (route_count_ff),
      .neighbour_count (neighbour_count_ff),
      .q_valid         (queue_valid),
      .q_item          (head_item),
      .q_pop           (pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp             (rsp)
   );

   // Pack the result.
   assign rsp_tuser = rsp.action;
   assign rsp_tdata = {4'b0000, rsp.checksum_out, rsp.ttl_out, rsp.next_mac, rsp.out_interface};

endmodule

FILE: dv/tb.sv
// Self-checking testbench of the IPv4 forwarding decision unit, with scoreboard and stimulus.
module tb;
   import ipv4fd_pkg::*;

   localparam int ROUTES     = 1024;
   localparam int NEIGHBOURS = 16;

   // Kind code that the block drops without a result.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Tracks the route and neighbor tables, predicts each decision and checks the results.
   class forwarding_scoreboard;
      logic [31:0] route_prefix      [ROUTES];
      logic [31:0] route_mask        [ROUTES];
      logic [31:0] route_hop         [ROUTES];
      logic [3:0]  route_iface       [ROUTES];
      logic [31:0] neighbour_address [NEIGHBOURS];
      logic [47:0] neighbour_mac     [NEIGHBOURS];
      logic [10:0] route_count;
      logic [4:0]  neighbour_count;
      rsp_type     expected_decisions [$];
      int          failures;

      function new();
         route_count     = '0;
         neighbour_count = '0;
         failures        = 0;
      endfunction

      function void set_register(logic index, logic [10:0] value);
         if (index == CSR_ROUTE_COUNT) begin
            route_count = value;
         end else begin
            neighbour_count = value[4:0];
         end
      endfunction

      // Incremental header checksum update in ones' complement arithmetic.
      function logic [15:0] adjust_checksum(logic [15:0] hc, logic [15:0] old_word,
                                            logic [15:0] new_word);
         logic [31:0] sum;
         sum = {16'h0, ~hc} + {16'h0, ~old_word} + {16'h0, new_word};
         sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
         sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
         return ~sum[15:0];
      endfunction

      // Applies one accepted request and queues the decision that a lookup must give.
      function void note_request(req_type r);
         rsp_type    decision;
         int         route_limit;
         int         neighbour_limit;
         int         best;
         int         slot;
         bit         found;
         bit         have_neighbour;
         logic [7:0] next_ttl;
         case (r.kind)
            KIND_ROUTE_WR: begin
               route_prefix[r.entry_index] = r.route_prefix_in;
               route_mask[r.entry_index]   = r.route_mask_in;
               route_hop[r.entry_index]    = r.hop_address;
               route_iface[r.entry_index]  = r.interface_in;
            end
            KIND_NEIGH_WR: begin
               if (r.entry_index < NEIGHBOURS) begin
                  neighbour_address[r.entry_index] = r.hop_address;
                  neighbour_mac[r.entry_index]     = r.mac_in;
               end
            end
            KIND_LOOKUP: begin
               decision        = '0;
               route_limit     = (route_count > ROUTES) ? ROUTES : route_count;
               neighbour_limit = (neighbour_count > NEIGHBOURS) ? NEIGHBOURS : neighbour_count;
               if (!r.header_ok) begin
                  decision.action = ACT_BAD_CSUM;
               end else if (r.ttl_in <= 8'd1) begin
                  decision.action = ACT_TIME_EXCEED;
               end else begin
                  // Largest mask value wins; on equal masks the lower index stays.
                  found = 1'b0;
                  best  = 0;
                  for (int i = 0; i < route_limit; i++) begin
                     if ((r.dest_address & route_mask[i]) == route_prefix[i] &&
                         (!found || route_mask[i] > route_mask[best])) begin
                        best  = i;
                        found = 1'b1;
                     end
                  end
                  if (!found) begin
                     decision.action = ACT_UNREACHABLE;
                  end else begin
                     // The first neighbor holding the next hop supplies the MAC.
                     have_neighbour = 1'b0;
                     slot           = 0;
                     for (int i = 0; i < neighbour_limit && !have_neighbour; i++) begin
                        if (neighbour_address[i] == route_hop[best]) begin
                           slot           = i;
                           have_neighbour = 1'b1;
                        end
                     end
                     if (!have_neighbour) begin
                        decision.action = ACT_NO_NEIGHBOR;
                     end else begin
                        next_ttl                = r.ttl_in - 8'd1;
                        decision.action         = ACT_FORWARD;
                        decision.out_interface  = route_iface[best];
                        decision.next_mac       = neighbour_mac[slot];
                        decision.ttl_out        = next_ttl;
                        decision.checksum_out   = adjust_checksum(r.checksum_in,
                                                                  {r.ttl_in, r.protocol_in},
                                                                  {next_ttl, r.protocol_in});
                     end
                  end
               end
               expected_decisions.push_back(decision);
            end
            default: begin
            end
         endcase
      endfunction

      // Compares one accepted result with the oldest pending decision.
      function void check_response(logic [2:0] action, logic [79:0] data);
         rsp_type oldest;
         if (expected_decisions.size() == 0) begin
            $error("Result with no lookup pending: action %0d", action);
            failures++;
            return;
         end
         oldest = expected_decisions.pop_front();
         if (action !== oldest.action) begin
            $error("action: expected %0d, actual %0d", oldest.action, action);
            failures++;
         end
         if (data[3:0] !== oldest.out_interface) begin
            $error("out_interface: expected %0d, actual %0d", oldest.out_interface, data[3:0]);
            failures++;
         end
         if (data[51:4] !== oldest.next_mac) begin
            $error("next_mac: expected %h, actual %h", oldest.next_mac, data[51:4]);
            failures++;
         end
         if (data[59:52] !== oldest.ttl_out) begin
            $error("ttl_out: expected %0d, actual %0d", oldest.ttl_out, data[59:52]);
            failures++;
         end
         if (data[75:60] !== oldest.checksum_out) begin
            $error("checksum_out: expected %h, actual %h", oldest.checksum_out, data[75:60]);
            failures++;
         end
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [1:0]   req_tuser  = '0;
   logic [223:0] req_tdata  = '0;
   logic         rsp_tready = 1'b0;
   logic         csr_valid  = 1'b0;
   logic         csr_index  = 1'b0;
   logic [10:0]  csr_data   = '0;
   wire          req_tready;
   wire          rsp_tvalid;
   wire  [2:0]   rsp_tuser;
   wire  [79:0]  rsp_tdata;
   wire          csr_ready;

   forwarding_scoreboard board = new();
   bit                   route_written [ROUTES];
   int                   idle_percent  = 0;
   int                   stall_left    = 0;

   ipv4_forwarding_decision_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: check each accepted result, then stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tuser, rsp_tdata);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(1, 100) <= idle_percent) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Fills every field with noise so that unused fields toggle too.
   function automatic req_type random_fields();
      logic [255:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   function automatic int written_prefix();
      int n;
      n = 0;
      while (n < ROUTES && route_written[n]) begin
         n++;
      end
      return n;
   endfunction

   // Presents one request, possibly after a random gap, and waits for it to be taken.
   task automatic send_request(input req_type r);
      if ($urandom_range(1, 100) <= idle_percent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {1'b0, r.header_ok, r.checksum_in, r.protocol_in, r.ttl_in,
                     r.dest_address, r.mac_in, r.interface_in, r.hop_address,
                     r.route_mask_in, r.route_prefix_in, r.entry_index};
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_request(r);
   endtask

   task automatic send_route(input int index, input logic [31:0] prefix,
                             input logic [31:0] mask, input logic [31:0] hop,
                             input logic [3:0] iface);
      req_type r;
      r                 = random_fields();
      r.kind            = KIND_ROUTE_WR;
      r.entry_index     = 10'(index);
      r.route_prefix_in = prefix;
      r.route_mask_in   = mask;
      r.hop_address     = hop;
      r.interface_in    = iface;
      send_request(r);
      route_written[index] = 1'b1;
   endtask

   task automatic send_neighbour(input int index, input logic [31:0] address,
                                 input logic [47:0] mac);
      req_type r;
      r             = random_fields();
      r.kind        = KIND_NEIGH_WR;
      r.entry_index = 10'(index);
      r.hop_address = address;
      r.mac_in      = mac;
      send_request(r);
   endtask

   task automatic send_lookup(input logic [31:0] dest, input logic [7:0] ttl,
                              input logic ok, input logic [15:0] csum);
      req_type r;
      r              = random_fields();
      r.kind         = KIND_LOOKUP;
      r.dest_address = dest;
      r.ttl_in       = ttl;
      r.header_ok    = ok;
      r.checksum_in  = csum;
      send_request(r);
   endtask

   // Mostly aims at a stored route with a live TTL and a good header.
   task automatic send_random_lookup();
      int          reach;
      int          entry;
      logic [31:0] dest;
      logic [7:0]  ttl;
      reach = (board.route_count > ROUTES) ? ROUTES : board.route_count;
      if (reach != 0 && $urandom_range(0, 4) != 0) begin
         entry = $urandom_range(0, reach - 1);
         dest  = (board.route_prefix[entry] & board.route_mask[entry]) |
                 ($urandom & ~board.route_mask[entry]);
      end else begin
         dest = $urandom;
      end
      case ($urandom_range(0, 9))
         0: ttl = 8'($urandom_range(0, 1));
         1: ttl = 8'd255;
         default: ttl = 8'($urandom_range(2, 254));
      endcase
      send_lookup(dest, ttl, $urandom_range(0, 9) != 0, 16'($urandom));
   endtask

   // Writes one random route with a mask of random length, sometimes a broken one.
   task automatic send_random_route(input int index, input int shortest, input int span);
      int          length;
      int          source;
      logic [31:0] mask;
      logic [31:0] base;
      logic [31:0] prefix;
      logic [31:0] hop;
      length = $urandom_range(shortest, 32);
      mask   = (length == 0) ? 32'h0 : ~32'h0 << (32 - length);
      if ($urandom_range(0, 9) == 0) begin
         mask = $urandom;
      end
      source = $urandom_range(0, span);
      base   = route_written[source] ? board.route_prefix[source] : $urandom;
      prefix = ($urandom_range(0, 11) == 0) ? $urandom : (base & mask);
      hop    = ($urandom_range(0, 3) != 0) ? board.neighbour_address[$urandom_range(0, 15)]
                                           : $urandom;
      send_route(index, prefix, mask, hop, 4'($urandom));
   endtask

   // One random request: lookups, table writes and the odd unused kind.
   task automatic send_random_item(input int span);
      int      pick;
      int      index;
      int      source;
      req_type r;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         send_random_lookup();
      end else if (pick < 80) begin
         index = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ROUTES - 1)
                                             : $urandom_range(0, span);
         send_random_route(index, 0, span);
      end else if (pick < 94) begin
         // Neighbor writes often pick up a route's next hop; indexes past the table drop.
         source = $urandom_range(0, span);
         send_neighbour($urandom_range(0, 31),
                        (route_written[source] && $urandom_range(0, 1) != 0)
                           ? board.route_hop[source] : $urandom,
                        {16'($urandom), $urandom});
      end else begin
         r      = random_fields();
         r.kind = KIND_UNUSED;
         send_request(r);
      end
   endtask

   // Waits until every pending decision has come back and the queue has drained.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.expected_decisions.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(input logic [10:0] routes, input logic [4:0] neighbours);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROUTE_COUNT;
      csr_data  <= routes;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_register(CSR_ROUTE_COUNT, routes);
      csr_index <= CSR_NEIGH_COUNT;
      csr_data  <= {6'd0, neighbours};
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_register(CSR_NEIGH_COUNT, {6'd0, neighbours});
      csr_valid <= 1'b0;
   endtask

   // Main sequence: directed checks, random phases, then the full route table.
   initial begin
      int          span;
      logic [10:0] routes;
      logic [4:0]  neighbours;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      configure(11'd0, 5'd0);

      // Empty tables: drop reasons, no route, unused kind and a neighbor write past the end.
      send_lookup(32'h0000_0000, 8'd0, 1'b0, 16'h1234);
      send_lookup(32'h0102_0304, 8'd0, 1'b1, 16'h0000);
      send_lookup(32'h0102_0304, 8'd1, 1'b1, 16'hFFFF);
      send_lookup(32'hFFFF_FFFF, 8'd255, 1'b1, 16'hABCD);
      send_request('1);
      send_neighbour(ROUTES - 1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);

      // Fill the neighbor table, with zero and all-ones MACs at the ends.
      for (int i = 0; i < NEIGHBOURS; i++) begin
         send_neighbour(i, {8'hAC, 24'($urandom)},
                        (i == 0) ? 48'h0 : (i == NEIGHBOURS - 1) ? '1
                                                                 : {16'($urandom), $urandom});
      end

      // Hand-built routes: nested prefixes, an equal-mask tie, a default route,
      // a host route with no neighbor, a broken mask and a prefix that never matches.
      send_route(0, 32'h0A00_0000, 32'hFF00_0000, board.neighbour_address[1], 4'd1);
      send_route(1, 32'h0A01_0000, 32'hFFFF_0000, board.neighbour_address[2], 4'd2);
      send_route(2, 32'h0A01_0000, 32'hFFFF_0000, board.neighbour_address[3], 4'd3);
      send_route(3, 32'h0000_0000, 32'h0000_0000, board.neighbour_address[15], 4'd15);
      send_route(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 4'd4);
      send_route(5, 32'h0A00_0100, 32'hFF00_FF00, board.neighbour_address[0], 4'd0);
      send_route(6, 32'hC0A8_0100, 32'hFFFF_FF00, board.neighbour_address[14], 4'd6);
      send_route(7, 32'h0000_00FF, 32'hFFFF_FF00, board.neighbour_address[5], 4'd7);
      settle();
      configure(11'd8, 5'd16);
      send_lookup(32'h0A01_0203, 8'd2, 1'b1, 16'h0000);
      send_lookup(32'h0A09_0909, 8'd255, 1'b1, 16'hFFFF);
      send_lookup(32'hFFFF_FFFF, 8'd64, 1'b1, 16'h5555);
      send_lookup(32'h0808_0808, 8'd64, 1'b1, 16'hAAAA);
      send_lookup(32'h0A55_01AA, 8'd17, 1'b1, 16'h8001);
      send_lookup(32'hC0A8_0107, 8'd3, 1'b1, 16'h7FFE);
      send_lookup(32'h0000_00FF, 8'd128, 1'b1, 16'h0F0F);

      // Random phases over small tables, each with its own counts and idling.
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         span = written_prefix();
         if (span > 64) begin
            span = 64;
         end
         routes     = 11'($urandom_range(0, span));
         neighbours = 5'($urandom_range(0, 31));
         if (phase == 0) begin
            neighbours = 5'd0;
         end else if (phase == 1) begin
            neighbours = 5'd31;
         end else if (phase == 2) begin
            routes     = 11'(span);
            neighbours = 5'd16;
         end
         idle_percent = (phase % 3 == 2) ? 0 : (phase % 3 == 0) ? 10 : 35;
         configure(routes, neighbours);
         repeat (50) send_random_item(span);
      end

      // Write every remaining route so the whole table can be searched.
      settle();
      idle_percent = 20;
      span         = written_prefix();
      for (int i = 0; i < ROUTES; i++) begin
         if (!route_written[i]) begin
            send_random_route(i, 16, (span > 0) ? span - 1 : 0);
         end
      end

      // Full table with no idling, then both counts past their table sizes.
      settle();
      idle_percent = 0;
      configure(11'd1024, 5'd16);
      repeat (10) send_random_lookup();
      settle();
      configure(11'd2047, 5'd31);
      repeat (10) send_random_lookup();
      settle();
      repeat (20) @(posedge clock);

      if (board.failures == 0 && board.expected_decisions.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #8000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
